// File: hdl/osm_pkg.sv
// Shared constants and codes for the order-statistic multiset.
`default_nettype none

package osm_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_DELETE = 3'd1;
    localparam logic [2:0] OP_RANK   = 3'd2;
    localparam logic [2:0] OP_VALUE  = 3'd3;
    localparam logic [2:0] OP_PRED   = 3'd4;
    localparam logic [2:0] OP_SUCC   = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ABSENT = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

endpackage

`default_nettype wire

// File: hdl/osm_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module osm_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: hdl/order_statistic_multiset.sv
// Top level: sequencer that keeps a sorted multiset in a RAM and answers queries.
//
// One transaction on the input channel carries an opcode and an operand; each
// produces exactly one transaction on the output channel (answer and status).
// A transaction is taken when valid is high and stall is low. The block works
// on one transaction at a time: in_stall stays high from the cycle after an
// accepted transaction until its result has been loaded into the output
// register. Insert, delete and the queries run a binary search over the sorted
// RAM, in which each probe reads an entry and then compares it with the
// operand. Insert and delete then shift the entries above the found position,
// reading each one through the read port and writing it back one place over
// through the write port, one entry per cycle. Value-at-rank needs no search
// and goes straight to a single fetch of the entry at that rank.
// A result waiting on a stalled receiver stays in the output register while
// the next input transaction is accepted and processed; the sequencer holds
// the following result until the output register is free. Reset clears the
// element count and all control state; RAM contents need no clearing since
// only entries below the count are ever read.
`default_nettype none

module order_statistic_multiset (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         opcode,
    input  wire logic signed [31:0] operand,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      answer,
    output logic [1:0]              status
);

    typedef enum logic [2:0] {
        IDLE,
        SEARCH,
        SEARCH_CMP,
        FETCH,
        FETCH_WAIT,
        SHIFT,
        PLACE,
        RESULT
    } state_t;

    state_t state_reg;

    logic [osm_pkg::CNT_W-1:0]  cnt_reg;
    logic [osm_pkg::CNT_W-1:0]  lo_reg;
    logic [osm_pkg::CNT_W-1:0]  hi_reg;
    logic [osm_pkg::CNT_W-1:0]  left_reg;
    logic [osm_pkg::ADDR_W-1:0] rd_idx_reg;
    logic [osm_pkg::ADDR_W-1:0] wr_idx_reg;
    logic [osm_pkg::ADDR_W-1:0] fetch_addr_reg;
    logic                       shift_up_reg;
    logic                       pend_reg;
    logic                       strict_reg;
    logic [2:0]                 op_reg;
    logic signed [31:0]         v_reg;
    logic signed [31:0]         res_answer_reg;
    logic [1:0]                 res_status_reg;
    logic                       out_valid_reg;
    logic signed [31:0]         answer_reg;
    logic [1:0]                 status_reg;

    logic [osm_pkg::CNT_W-1:0]  mid;
    logic [osm_pkg::CNT_W-1:0]  p;
    logic signed [31:0]         elem;
    logic                       go_right;
    logic signed [31:0]         operand_m1;
    logic                       ram_we;
    logic [osm_pkg::ADDR_W-1:0] ram_waddr;
    logic [31:0]                ram_wdata;
    logic [osm_pkg::ADDR_W-1:0] ram_raddr;
    logic [31:0]                ram_rdata;

    osm_ram #(
        .DEPTH (osm_pkg::CAPACITY),
        .WIDTH (osm_pkg::DATA_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign mid        = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign p          = lo_reg;
    assign elem       = $signed(ram_rdata);
    assign go_right   = strict_reg ? (elem <= v_reg) : (elem < v_reg);
    assign operand_m1 = operand - 32'sd1;

    // RAM address and write selection follow the sequencer state.
    always_comb
    begin
        ram_raddr = rd_idx_reg;
        ram_we    = 1'b0;
        ram_waddr = wr_idx_reg;
        ram_wdata = ram_rdata;
        case (state_reg)
            SEARCH:
            begin
                ram_raddr = mid[osm_pkg::ADDR_W-1:0];
            end
            FETCH:
            begin
                ram_raddr = fetch_addr_reg;
            end
            SHIFT:
            begin
                ram_raddr = rd_idx_reg;
                ram_we    = pend_reg;
            end
            PLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = p[osm_pkg::ADDR_W-1:0];
                ram_wdata = v_reg;
            end
            default:
            begin
                ram_raddr = rd_idx_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            pend_reg       <= 1'b0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            left_reg       <= '0;
            rd_idx_reg     <= '0;
            wr_idx_reg     <= '0;
            fetch_addr_reg <= '0;
            shift_up_reg   <= 1'b0;
            strict_reg     <= 1'b0;
            op_reg         <= osm_pkg::OP_INSERT;
        end
        else
        begin
            if (out_valid_reg && !out_stall && state_reg != RESULT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= opcode;
                        v_reg          <= operand;
                        lo_reg         <= '0;
                        hi_reg         <= cnt_reg;
                        res_answer_reg <= '0;
                        res_status_reg <= osm_pkg::ST_OK;
                        case (opcode)
                            osm_pkg::OP_INSERT:
                            begin
                                strict_reg <= 1'b1;
                                if (cnt_reg >= osm_pkg::CNT_W'(osm_pkg::CAPACITY))
                                begin
                                    res_status_reg <= osm_pkg::ST_FULL;
                                    state_reg      <= RESULT;
                                end
                                else
                                begin
                                    state_reg <= SEARCH;
                                end
                            end
                            osm_pkg::OP_DELETE, osm_pkg::OP_RANK, osm_pkg::OP_PRED:
                            begin
                                strict_reg <= 1'b0;
                                state_reg  <= SEARCH;
                            end
                            osm_pkg::OP_SUCC:
                            begin
                                strict_reg <= 1'b1;
                                state_reg  <= SEARCH;
                            end
                            osm_pkg::OP_VALUE:
                            begin
                                if (operand >= 32'sd1 && operand <= $signed(32'(cnt_reg)))
                                begin
                                    fetch_addr_reg <= operand_m1[osm_pkg::ADDR_W-1:0];
                                    state_reg      <= FETCH;
                                end
                                else
                                begin
                                    res_status_reg <= osm_pkg::ST_ABSENT;
                                    state_reg      <= RESULT;
                                end
                            end
                            default:
                            begin
                                res_status_reg <= osm_pkg::ST_ABSENT;
                                state_reg      <= RESULT;
                            end
                        endcase
                    end
                end
                SEARCH:
                begin
                    if (lo_reg < hi_reg)
                    begin
                        state_reg <= SEARCH_CMP;
                    end
                    else
                    begin
                        case (op_reg)
                            osm_pkg::OP_INSERT:
                            begin
                                // Move entries p..count-1 up by one, top first.
                                left_reg     <= cnt_reg - p;
                                rd_idx_reg   <= osm_pkg::ADDR_W'(cnt_reg - 1'b1);
                                wr_idx_reg   <= cnt_reg[osm_pkg::ADDR_W-1:0];
                                shift_up_reg <= 1'b0;
                                pend_reg     <= 1'b0;
                                state_reg    <= SHIFT;
                            end
                            osm_pkg::OP_DELETE, osm_pkg::OP_SUCC:
                            begin
                                if (p < cnt_reg)
                                begin
                                    fetch_addr_reg <= p[osm_pkg::ADDR_W-1:0];
                                    state_reg      <= FETCH;
                                end
                                else
                                begin
                                    res_status_reg <= osm_pkg::ST_ABSENT;
                                    state_reg      <= RESULT;
                                end
                            end
                            osm_pkg::OP_PRED:
                            begin
                                if (p != '0)
                                begin
                                    fetch_addr_reg <= osm_pkg::ADDR_W'(p - 1'b1);
                                    state_reg      <= FETCH;
                                end
                                else
                                begin
                                    res_status_reg <= osm_pkg::ST_ABSENT;
                                    state_reg      <= RESULT;
                                end
                            end
                            default:
                            begin
                                res_answer_reg <= $signed(32'(p) + 32'd1);
                                state_reg      <= RESULT;
                            end
                        endcase
                    end
                end
                SEARCH_CMP:
                begin
                    if (go_right)
                    begin
                        lo_reg <= mid + 1'b1;
                    end
                    else
                    begin
                        hi_reg <= mid;
                    end
                    state_reg <= SEARCH;
                end
                FETCH:
                begin
                    state_reg <= FETCH_WAIT;
                end
                FETCH_WAIT:
                begin
                    if (op_reg == osm_pkg::OP_DELETE)
                    begin
                        if (elem == v_reg)
                        begin
                            // Move entries p+1..count-1 down by one, bottom first.
                            left_reg     <= cnt_reg - p - 1'b1;
                            rd_idx_reg   <= osm_pkg::ADDR_W'(p + 1'b1);
                            wr_idx_reg   <= p[osm_pkg::ADDR_W-1:0];
                            shift_up_reg <= 1'b1;
                            pend_reg     <= 1'b0;
                            state_reg    <= SHIFT;
                        end
                        else
                        begin
                            res_status_reg <= osm_pkg::ST_ABSENT;
                            state_reg      <= RESULT;
                        end
                    end
                    else
                    begin
                        res_answer_reg <= elem;
                        state_reg      <= RESULT;
                    end
                end
                SHIFT:
                begin
                    // Read one entry per cycle; the data read last cycle is written now.
                    if (left_reg != '0)
                    begin
                        left_reg   <= left_reg - 1'b1;
                        rd_idx_reg <= shift_up_reg ? rd_idx_reg + 1'b1 : rd_idx_reg - 1'b1;
                        pend_reg   <= 1'b1;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        wr_idx_reg <= shift_up_reg ? wr_idx_reg + 1'b1 : wr_idx_reg - 1'b1;
                    end
                    if (left_reg == '0 && !pend_reg)
                    begin
                        if (op_reg == osm_pkg::OP_INSERT)
                        begin
                            state_reg <= PLACE;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= RESULT;
                        end
                    end
                end
                PLACE:
                begin
                    cnt_reg   <= cnt_reg + 1'b1;
                    state_reg <= RESULT;
                end
                RESULT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        answer_reg    <= res_answer_reg;
                        status_reg    <= res_status_reg;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;
    assign status    = status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= osm_pkg::CNT_W'(osm_pkg::CAPACITY))
    else $error("element count above capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
    else $error("block ready again right after accepting a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg != $past(cnt_reg)) |-> ($past(state_reg) == PLACE ||
                                         $past(state_reg) == SHIFT))
    else $error("element count changed outside insert or delete");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(answer_reg)))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire
